>>> design/tsq_pkg.sv
// Shared types and constants for the two-stack FIFO queue.
`default_nettype none

package tsq_pkg;

   // Fixed widths of the transaction fields
   localparam int VALUE_WIDTH  = 32;
   localparam int STATUS_WIDTH = 2;

   // Command codes
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   // Status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

   // Value returned by a dequeue on an empty queue, and by every enqueue
   localparam logic signed [VALUE_WIDTH-1:0] EMPTY_VALUE = -32'sd1;
   localparam logic signed [VALUE_WIDTH-1:0] ENQ_VALUE   = 32'sd0;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEQ_READ,
      ST_MOVE
   } state_type;

endpackage

`default_nettype wire

>>> design/tsq_ram.sv
// Simple dual-port stack memory: one write port, one registered read port.
`default_nettype none

module tsq_ram #(
   parameter int DEPTH      = 256,
   parameter int WIDTH      = 32,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire        [ADDR_WIDTH-1:0]  wr_addr,
   input  wire        [WIDTH-1:0]       wr_data,
   input  wire                          rd_en,
   input  wire        [ADDR_WIDTH-1:0]  rd_addr,
   output logic       [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered; holds its data when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> design/two_stack_fifo_queue.sv
// Top level of the two-stack FIFO queue: controller and the two stack memories.
//
// Usage: a transaction is taken at a rising edge with start high and busy low.
// req_command selects enqueue (0) or dequeue (1); req_value_in is the value to
// enqueue. Every transaction gives exactly one result, shown for one cycle on
// rsp_value_out / rsp_status with rsp_valid high; the receiver cannot stall.
// Enqueue: the value is written into the input stack memory at the accept edge;
// the result follows in the next cycle, busy stays low (one item per cycle).
// A full input stack drops the value with status 2.
// Dequeue with the output stack holding entries: one read of the output stack
// memory, then the response register; busy holds off new requests until then.
// Dequeue with both stacks empty: -1 with status 1 next cycle; busy stays low.
// Dequeue with only the input stack holding n entries: the entries are moved
// one per cycle through the input memory read port into the output memory;
// the last one moved is returned directly. Each value crosses once.
// Reset clears both stack counts and the controller; the memories need no
// clearing since only entries below a count are ever read.
`default_nettype none

module two_stack_fifo_queue #(
   parameter int STACK_DEPTH = 256,
   parameter int DATA_WIDTH  = 32
) (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          start,
   output logic                                         busy,
   input  wire                                          req_command,
   input  wire  signed [tsq_pkg::VALUE_WIDTH-1:0]       req_value_in,
   output logic                                         rsp_valid,
   output logic signed [tsq_pkg::VALUE_WIDTH-1:0]       rsp_value_out,
   output logic        [tsq_pkg::STATUS_WIDTH-1:0]      rsp_status
);

   localparam int ADDR_WIDTH = $clog2(STACK_DEPTH);
   localparam int CNT_WIDTH  = $clog2(STACK_DEPTH + 1);

   tsq_pkg::state_type state_ff, state_in;

   logic [CNT_WIDTH-1:0] in_count_ff, in_count_in;
   logic [CNT_WIDTH-1:0] out_count_ff, out_count_in;
   logic [CNT_WIDTH-1:0] in_dec, out_dec;
   logic                 pending_ff, pending_in;

   logic                                       rsp_valid_ff, rsp_valid_in;
   logic signed [tsq_pkg::VALUE_WIDTH-1:0]     rsp_value_ff, rsp_value_in;
   logic        [tsq_pkg::STATUS_WIDTH-1:0]    rsp_status_ff, rsp_status_in;

   // Memory port controls
   logic                         in_wr_en, in_rd_en, out_wr_en, out_rd_en;
   logic        [ADDR_WIDTH-1:0] in_wr_addr, in_rd_addr, out_wr_addr, out_rd_addr;
   logic signed [DATA_WIDTH-1:0] in_wr_data, in_rd_data, out_rd_data;

   // Stored form keeps the low DATA_WIDTH bits of the sign-extended input
   assign in_wr_data = DATA_WIDTH'(req_value_in);

   assign in_dec  = in_count_ff - CNT_WIDTH'(1);
   assign out_dec = out_count_ff - CNT_WIDTH'(1);

   tsq_ram #(
      .DEPTH      (STACK_DEPTH),
      .WIDTH      (DATA_WIDTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_in_stack (
      .clock   (clock),
      .wr_en   (in_wr_en),
      .wr_addr (in_wr_addr),
      .wr_data (in_wr_data),
      .rd_en   (in_rd_en),
      .rd_addr (in_rd_addr),
      .rd_data (in_rd_data)
   );

   tsq_ram #(
      .DEPTH      (STACK_DEPTH),
      .WIDTH      (DATA_WIDTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_out_stack (
      .clock   (clock),
      .wr_en   (out_wr_en),
      .wr_addr (out_wr_addr),
      .wr_data (in_rd_data),
      .rd_en   (out_rd_en),
      .rd_addr (out_rd_addr),
      .rd_data (out_rd_data)
   );

   // State, counts and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsq_pkg::ST_IDLE;
         in_count_ff  <= '0;
         out_count_ff <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Next state, memory controls and response
   always_comb begin
      state_in      = state_ff;
      in_count_in   = in_count_ff;
      out_count_in  = out_count_ff;
      pending_in    = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      in_wr_en      = 1'b0;
      in_rd_en      = 1'b0;
      out_wr_en     = 1'b0;
      out_rd_en     = 1'b0;
      in_wr_addr    = in_count_ff[ADDR_WIDTH-1:0];
      in_rd_addr    = in_dec[ADDR_WIDTH-1:0];
      out_wr_addr   = out_count_ff[ADDR_WIDTH-1:0];
      out_rd_addr   = out_dec[ADDR_WIDTH-1:0];

      case (state_ff)
         tsq_pkg::ST_IDLE: begin
            if (start) begin
               if (req_command == tsq_pkg::CMD_ENQUEUE) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = tsq_pkg::ENQ_VALUE;
                  if (in_count_ff != CNT_WIDTH'(STACK_DEPTH)) begin
                     in_wr_en      = 1'b1;
                     in_count_in   = in_count_ff + CNT_WIDTH'(1);
                     rsp_status_in = tsq_pkg::ST_OK;
                  end else begin
                     rsp_status_in = tsq_pkg::ST_FULL;
                  end
               end else if (out_count_ff != '0) begin
                  // pop the output stack
                  out_rd_en    = 1'b1;
                  out_count_in = out_dec;
                  state_in     = tsq_pkg::ST_DEQ_READ;
               end else if (in_count_ff != '0) begin
                  state_in = tsq_pkg::ST_MOVE;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = tsq_pkg::EMPTY_VALUE;
                  rsp_status_in = tsq_pkg::ST_EMPTY;
               end
            end
         end

         tsq_pkg::ST_DEQ_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = tsq_pkg::VALUE_WIDTH'(out_rd_data);
            rsp_status_in = tsq_pkg::ST_OK;
            state_in      = tsq_pkg::ST_IDLE;
         end

         tsq_pkg::ST_MOVE: begin
            if (in_count_ff != '0) begin
               // read the next input entry, write the previous one across
               in_rd_en    = 1'b1;
               in_count_in = in_dec;
               pending_in  = 1'b1;
               if (pending_ff) begin
                  out_wr_en    = 1'b1;
                  out_count_in = out_count_ff + CNT_WIDTH'(1);
               end
            end else begin
               // last entry moved is the oldest: return it instead of storing
               rsp_valid_in  = 1'b1;
               rsp_value_in  = tsq_pkg::VALUE_WIDTH'(in_rd_data);
               rsp_status_in = tsq_pkg::ST_OK;
               state_in      = tsq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tsq_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff != tsq_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire
